@@ hdl/srpg_pkg.sv @@
package srpg_pkg;

   localparam int RAMP_DEPTH_DEF = 1024;
   localparam int INTV_W         = 16;   // integer interval width
   localparam int D_W            = 24;   // Q16.8 interval width
   localparam int DIV_N          = D_W + 1;  // dividend bits (2*d)
   localparam int CNT_W          = $clog2(DIV_N);
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 16;
   localparam logic [15:0] FIRST_RST = 16'd2000;
   localparam logic [15:0] MIN_RST   = 16'd100;
   localparam logic [15:0] SCALE_RST = 16'd256;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_START = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NOP   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_ACCEL  = 2'd1,
      PH_CRUISE = 2'd2,
      PH_DECEL  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_CALC,
      S_FIN,
      S_OUT
   } fsm_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST = 1'b0,
      CSR_MIN   = 1'b1
   } csr_type;

endpackage

@@ hdl/srpg_if.sv @@
interface srpg_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [31:0] target_steps;
   logic [15:0]        speed_scale;
   logic               hold;
   modport source (output valid, kind, target_steps, speed_scale, hold, input ready);
   modport sink   (input valid, kind, target_steps, speed_scale, hold, output ready);
endinterface

interface srpg_rsp_if;
   logic               valid;
   logic               ready;
   logic               step_pulse;
   logic               direction;
   logic signed [31:0] position;
   logic               busy_res;
   logic               done_res;
   modport source (output valid, step_pulse, direction, position, busy_res, done_res,
                   input ready);
   modport sink   (input valid, step_pulse, direction, position, busy_res, done_res,
                   output ready);
endinterface

@@ hdl/srpg_ram.sv @@
module srpg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

@@ hdl/stepper_ramp_pulse_generator.sv @@
// Each item passes through the output state into the registered result; a step item first
// goes through ramp read, the serial divide/multiply, and finish before output.
// A new item is accepted only in the idle state, once the last item's result is registered;
// a result not yet taken by the receiver holds the block in its output state.
// Reset (synchronous, active high) restores state and CSRs to defaults, position 0, idle.
module stepper_ramp_pulse_generator #(
   parameter int RAMP_DEPTH = srpg_pkg::RAMP_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   srpg_req_if.sink                          req_ch,
   srpg_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [srpg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [srpg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   localparam int AW  = $clog2(RAMP_DEPTH);
   localparam int RLW = $clog2(RAMP_DEPTH + 1);   // ramp length holds the depth itself
   localparam int DVW = RLW + 2;                   // divisor 4n+1

   // control and model state
   srpg_pkg::fsm_type   fsm_ff, fsm_in;
   srpg_pkg::phase_type phase_ff, phase_in;
   logic [31:0]         pos_ff, pos_in;
   logic [31:0]         steps_ff, steps_in;
   logic [31:0]         mlen_ff, mlen_in;
   logic [RLW-1:0]      ri_ff, ri_in;
   logic [RLW-1:0]      rl_ff, rl_in;
   logic [23:0]         d_ff, d_in;
   logic [23:0]         tick_ff, tick_in;
   logic                dir_ff, dir_in;
   logic [15:0]         scale_ff, scale_in;
   logic [15:0]         first_ff, first_in;
   logic [15:0]         min_ff, min_in;
   // serial arithmetic
   logic [15:0]               mcand_ff, mcand_in;
   logic [31:0]               prod_ff, prod_in;
   logic [DVW-1:0]            rem_ff, rem_in;
   logic [DVW-1:0]            div_ff, div_in;
   logic [srpg_pkg::DIV_N-1:0] quo_ff, quo_in;
   logic [srpg_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   // per-item flags and result register
   logic pulse_ff, pulse_in, done_ff, done_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_pulse_ff, rsp_pulse_in, rsp_dir_ff, rsp_dir_in;
   logic rsp_busy_ff, rsp_busy_in, rsp_done_ff, rsp_done_in;
   logic [31:0] rsp_pos_ff, rsp_pos_in;

   // ramp store
   logic           ram_we;
   logic [AW-1:0]  ram_raddr;
   logic [15:0]    ram_rdata;
   logic [RLW-1:0] ri_dec;
   logic [RLW-1:0] rl_inc;

   assign rl_inc    = rl_ff + RLW'(1);
   assign ri_dec    = (ri_ff == '0) ? '0 : ri_ff - RLW'(1);
   assign ram_raddr = ri_dec[AW-1:0];

   srpg_ram #(.WIDTH(srpg_pkg::INTV_W), .DEPTH(RAMP_DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (rl_ff[AW-1:0]),
      .wdata (d_ff[23:8]),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_ch.ready      = (fsm_ff == srpg_pkg::S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.step_pulse = rsp_pulse_ff;
   assign rsp_ch.direction  = rsp_dir_ff;
   assign rsp_ch.position   = rsp_pos_ff;
   assign rsp_ch.busy_res   = rsp_busy_ff;
   assign rsp_ch.done_res   = rsp_done_ff;

   always_comb begin
      logic [32:0] diff;
      logic [32:0] mag;
      logic [16:0] msum;
      logic [DVW:0] rsh;
      logic [24:0] dn;
      logic [23:0] flr;
      logic [23:0] w;
      srpg_pkg::phase_type ph;

      fsm_in = fsm_ff;     phase_in = phase_ff;  pos_in = pos_ff;
      steps_in = steps_ff; mlen_in = mlen_ff;    ri_in = ri_ff;
      rl_in = rl_ff;       d_in = d_ff;          tick_in = tick_ff;
      dir_in = dir_ff;     scale_in = scale_ff;  first_in = first_ff;
      min_in = min_ff;     mcand_in = mcand_ff;  prod_in = prod_ff;
      rem_in = rem_ff;     div_in = div_ff;      quo_in = quo_ff;
      cnt_in = cnt_ff;     pulse_in = pulse_ff;  done_in = done_ff;
      rsp_pulse_in = rsp_pulse_ff; rsp_dir_in = rsp_dir_ff; rsp_pos_in = rsp_pos_ff;
      rsp_busy_in = rsp_busy_ff;   rsp_done_in = rsp_done_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      ram_we = 1'b0;
      diff = '0; mag = '0; msum = '0; rsh = '0; dn = '0; flr = '0; w = '0;
      ph = phase_ff;

      if (csr_we) begin
         unique case (srpg_pkg::csr_type'(csr_index))
            srpg_pkg::CSR_FIRST: first_in = csr_wdata;
            srpg_pkg::CSR_MIN:   min_in   = csr_wdata;
            default: ;
         endcase
      end

      unique case (fsm_ff)
         srpg_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               pulse_in = 1'b0;
               done_in  = 1'b0;
               fsm_in   = srpg_pkg::S_OUT;
               unique case (srpg_pkg::kind_type'(req_ch.kind))
                  srpg_pkg::KIND_TICK: begin
                     if (phase_ff != srpg_pkg::PH_IDLE && !req_ch.hold) begin
                        if (tick_ff == '0) begin
                           // issue a step, then work out the next wait serially
                           pulse_in = 1'b1;
                           pos_in   = dir_ff ? pos_ff + 32'd1 : pos_ff - 32'd1;
                           steps_in = steps_ff - 32'd1;
                           mcand_in = d_ff[23:8];
                           prod_in  = {16'd0, scale_ff};
                           rem_in   = '0;
                           quo_in   = {d_ff, 1'b0};
                           div_in   = {rl_inc, 2'b01};
                           cnt_in   = '0;
                           fsm_in   = srpg_pkg::S_LOAD;
                           unique case (phase_ff)
                              srpg_pkg::PH_ACCEL: begin
                                 ram_we = (rl_ff < RLW'(RAMP_DEPTH));
                                 rl_in  = rl_inc;
                                 ri_in  = rl_inc;
                              end
                              srpg_pkg::PH_DECEL: ri_in = ri_dec;
                              default: ;
                           endcase
                        end else begin
                           tick_in = tick_ff - 24'd1;
                        end
                     end
                  end
                  srpg_pkg::KIND_START: begin
                     diff = {req_ch.target_steps[31], req_ch.target_steps}
                          - {pos_ff[31], pos_ff};
                     mag  = diff[32] ? -diff : diff;
                     tick_in = '0;
                     if (diff == '0) begin
                        phase_in = srpg_pkg::PH_IDLE;
                        steps_in = '0;
                     end else begin
                        dir_in   = ~diff[32];
                        steps_in = mag[31:0];
                        mlen_in  = mag[31:0];
                        scale_in = req_ch.speed_scale;
                        ri_in    = '0;
                        rl_in    = '0;
                        d_in     = {first_ff, 8'd0};
                        phase_in = srpg_pkg::PH_ACCEL;
                     end
                  end
                  srpg_pkg::KIND_CLEAR: pos_in = '0;
                  default: ;
               endcase
            end
         end
         srpg_pkg::S_LOAD: begin
            // decel takes its interval from the ramp store read issued last cycle
            if (phase_ff == srpg_pkg::PH_DECEL) begin
               mcand_in = ram_rdata;
            end
            fsm_in = srpg_pkg::S_CALC;
         end
         srpg_pkg::S_CALC: begin
            // shift-add multiply, one scale bit a cycle
            if (cnt_ff < srpg_pkg::CNT_W'(16)) begin
               msum    = {1'b0, prod_ff[31:16]} + (prod_ff[0] ? {1'b0, mcand_ff} : 17'd0);
               prod_in = {msum, prod_ff[15:1]};
            end
            // restoring divide of 2d by 4n+1, one quotient bit a cycle
            rsh = {rem_ff, quo_ff[srpg_pkg::DIV_N-1]};
            if (rsh >= {1'b0, div_ff}) begin
               rem_in = DVW'(rsh - {1'b0, div_ff});
               quo_in = {quo_ff[srpg_pkg::DIV_N-2:0], 1'b1};
            end else begin
               rem_in = rsh[DVW-1:0];
               quo_in = {quo_ff[srpg_pkg::DIV_N-2:0], 1'b0};
            end
            cnt_in = cnt_ff + srpg_pkg::CNT_W'(1);
            if (cnt_ff == srpg_pkg::CNT_W'(srpg_pkg::DIV_N - 1)) begin
               fsm_in = srpg_pkg::S_FIN;
            end
         end
         srpg_pkg::S_FIN: begin
            w = (prod_ff[31:8] == '0) ? 24'd1 : prod_ff[31:8];
            if (phase_ff == srpg_pkg::PH_ACCEL) begin
               dn  = {1'b0, d_ff} - quo_ff;
               flr = {min_ff, 8'd0};
               if (dn[23:0] <= flr) begin
                  d_in = flr;
                  ph   = srpg_pkg::PH_CRUISE;
               end else begin
                  d_in = dn[23:0];
               end
               if (32'(rl_ff) >= (mlen_ff >> 1) || rl_ff >= RLW'(RAMP_DEPTH)) begin
                  ph = srpg_pkg::PH_CRUISE;
               end
            end
            if (steps_ff == '0) begin
               ph      = srpg_pkg::PH_IDLE;
               tick_in = '0;
               done_in = 1'b1;
            end else begin
               if (ph != srpg_pkg::PH_DECEL && steps_ff <= 32'(rl_ff)) begin
                  ph = srpg_pkg::PH_DECEL;
               end
               tick_in = w - 24'd1;
            end
            phase_in = ph;
            fsm_in   = srpg_pkg::S_OUT;
         end
         srpg_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pulse_in = pulse_ff;
               rsp_dir_in   = dir_ff;
               rsp_pos_in   = pos_ff;
               rsp_busy_in  = (phase_ff != srpg_pkg::PH_IDLE);
               rsp_done_in  = done_ff;
               fsm_in       = srpg_pkg::S_IDLE;
            end
         end
         default: fsm_in = srpg_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= srpg_pkg::S_IDLE;
         phase_ff     <= srpg_pkg::PH_IDLE;
         pos_ff       <= '0;
         steps_ff     <= '0;
         mlen_ff      <= '0;
         ri_ff        <= '0;
         rl_ff        <= '0;
         d_ff         <= '0;
         tick_ff      <= '0;
         dir_ff       <= 1'b0;
         scale_ff     <= srpg_pkg::SCALE_RST;
         first_ff     <= srpg_pkg::FIRST_RST;
         min_ff       <= srpg_pkg::MIN_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         steps_ff     <= steps_in;
         mlen_ff      <= mlen_in;
         ri_ff        <= ri_in;
         rl_ff        <= rl_in;
         d_ff         <= d_in;
         tick_ff      <= tick_in;
         dir_ff       <= dir_in;
         scale_ff     <= scale_in;
         first_ff     <= first_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mcand_ff     <= mcand_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      pulse_ff     <= pulse_in;
      done_ff      <= done_in;
      rsp_pulse_ff <= rsp_pulse_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_busy_ff  <= rsp_busy_in;
      rsp_done_ff  <= rsp_done_in;
   end

`ifndef NO_ASSERTIONS
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> !rsp_busy_ff && rsp_pulse_ff)
      else $error("done result while still busy or without a step");
   a_ramp_bound: assert property (@(posedge clock) disable iff (reset)
      rl_ff <= RLW'(RAMP_DEPTH))
      else $error("ramp length beyond store depth");
   a_decel_ramp: assert property (@(posedge clock) disable iff (reset)
      phase_ff == srpg_pkg::PH_DECEL |-> rl_ff != '0)
      else $error("deceleration with empty ramp");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=> rsp_valid_ff && $stable(rsp_pos_ff))
      else $error("result dropped before it was taken");
`endif
endmodule

@@ test/stepper_ramp_pulse_generator_tb.sv @@
module stepper_ramp_pulse_generator_tb;

   // One expected result per item: the block answers every item.
   typedef struct packed {
      logic               step_pulse;
      logic               direction;
      logic signed [31:0] position;
      logic               busy_res;
      logic               done_res;
   } motion_result_type;

   // Scoreboard: owns its own copy of the motor state and predicts each result.
   class step_scoreboard;
      logic [15:0] first_iv, min_iv;
      logic [31:0] pos, left, move_len;
      int unsigned ramp_idx, ramp_len;
      logic [23:0] d_q;
      logic [23:0] countdown;
      srpg_pkg::phase_type phase;
      logic        dir;
      logic [15:0] scale;
      logic [15:0] ramp_mem [srpg_pkg::RAMP_DEPTH_DEF];
      motion_result_type pending[$];
      int errors, checked, steps_seen, moves_done;

      function void clear_state();
         first_iv = srpg_pkg::FIRST_RST; min_iv = srpg_pkg::MIN_RST;
         pos = 0; left = 0; move_len = 0; ramp_idx = 0; ramp_len = 0;
         d_q = 0; countdown = 0; phase = srpg_pkg::PH_IDLE; dir = 0;
         scale = srpg_pkg::SCALE_RST;
         errors = 0; checked = 0; steps_seen = 0; moves_done = 0;
      endfunction

      function void write_reg(srpg_pkg::csr_type idx, logic [15:0] val);
         if (idx == srpg_pkg::CSR_FIRST) first_iv = val;
         else min_iv = val;
      endfunction

      function logic [23:0] stretch(logic [15:0] whole);
         logic [39:0] w;
         w = ({24'd0, whole} * {24'd0, scale}) >> 8;
         if (w < 1) w = 1;
         if (w > 40'hFFFFFF) w = 40'hFFFFFF;
         return w[23:0];
      endfunction

      // Issues one step; returns 1 on the final step of the move.
      function bit take_step();
         logic [23:0] w;
         logic [15:0] whole;
         logic [63:0] dd, floor_d;
         bit ended;
         pos = dir ? pos + 1 : pos - 1;
         left = left - 1;
         if (phase == srpg_pkg::PH_ACCEL) begin
            whole = d_q[23:8];
            dd = {40'd0, d_q};
            floor_d = {40'd0, min_iv, 8'd0};
            ended = 0;
            if (ramp_len < srpg_pkg::RAMP_DEPTH_DEF) ramp_mem[ramp_len] = whole;
            ramp_len++;
            ramp_idx = ramp_len;
            w = stretch(whole);
            dd = dd - (64'd2 * dd) / (64'd4 * 64'(ramp_len) + 64'd1);
            if (dd <= floor_d) begin
               dd = floor_d;
               ended = 1;
            end
            d_q = dd[23:0];
            if (ended || ramp_len >= move_len / 2 || ramp_len >= srpg_pkg::RAMP_DEPTH_DEF)
               phase = srpg_pkg::PH_CRUISE;
         end else if (phase == srpg_pkg::PH_CRUISE) begin
            w = stretch(d_q[23:8]);
         end else begin
            if (ramp_idx > 0) ramp_idx--;
            w = stretch(ramp_mem[ramp_idx]);
         end
         if (left == 0) begin
            phase = srpg_pkg::PH_IDLE;
            countdown = 0;
            return 1;
         end
         if (phase != srpg_pkg::PH_DECEL && left <= ramp_len) phase = srpg_pkg::PH_DECEL;
         countdown = w - 24'd1;
         return 0;
      endfunction

      function void note_item(srpg_pkg::kind_type k, logic signed [31:0] tgt,
                              logic [15:0] sc, logic hold);
         motion_result_type r;
         logic signed [32:0] diff;
         r = '0;
         case (k)
            srpg_pkg::KIND_TICK: begin
               if (phase != srpg_pkg::PH_IDLE && !hold) begin
                  if (countdown == 0) begin
                     r.step_pulse = 1;
                     steps_seen++;
                     if (take_step()) begin
                        r.done_res = 1;
                        moves_done++;
                     end
                  end else countdown--;
               end
            end
            srpg_pkg::KIND_START: begin
               diff = 33'(tgt) - 33'(signed'(pos));
               if (diff == 0) begin
                  phase = srpg_pkg::PH_IDLE; left = 0; countdown = 0;
               end else begin
                  dir = diff > 0;
                  left = diff > 0 ? diff[31:0] : 32'(-diff);
                  move_len = left;
                  scale = sc;
                  ramp_idx = 0; ramp_len = 0;
                  d_q = {first_iv, 8'd0};
                  countdown = 0;
                  phase = srpg_pkg::PH_ACCEL;
               end
            end
            srpg_pkg::KIND_CLEAR: pos = 0;
            default: ;
         endcase
         r.direction = dir;
         r.position = pos;
         r.busy_res = phase != srpg_pkg::PH_IDLE;
         pending.push_back(r);
      endfunction

      function void check_result(motion_result_type got);
         motion_result_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.step_pulse !== want.step_pulse)
            $display("%0t: step_pulse exp %0b got %0b", $time, want.step_pulse, got.step_pulse);
         if (got.direction !== want.direction)
            $display("%0t: direction exp %0b got %0b", $time, want.direction, got.direction);
         if (got.position !== want.position)
            $display("%0t: position exp %0d got %0d", $time, want.position, got.position);
         if (got.busy_res !== want.busy_res)
            $display("%0t: busy_res exp %0b got %0b", $time, want.busy_res, got.busy_res);
         if (got.done_res !== want.done_res)
            $display("%0t: done_res exp %0b got %0b", $time, want.done_res, got.done_res);
         if (got !== want) errors++;
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   srpg_pkg::csr_type csr_index = srpg_pkg::CSR_FIRST;
   logic [srpg_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   srpg_req_if req_ch ();
   srpg_rsp_if rsp_ch ();

   step_scoreboard motion_sb = new();
   bit stalls_on = 1;   // receiver back-pressure on or off for the current phase
   int rx_wait = 0;     // cycles the receiver still holds off before the next item
   int sent = 0;

   stepper_ramp_pulse_generator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.kind = srpg_pkg::KIND_NOP;
      req_ch.target_steps = 0;
      req_ch.speed_scale = srpg_pkg::SCALE_RST;
      req_ch.hold = 0;
      rsp_ch.ready = 0;
   end

   // Sends one item: optional random gap, then hold valid until the handshake.
   task automatic send_item(srpg_pkg::kind_type k, logic signed [31:0] tgt,
                            logic [15:0] sc, logic hold, bit gaps);
      int gap;
      gap = gaps ? int'($urandom_range(0, 19)) : 0;
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.kind <= k;
      req_ch.target_steps <= tgt;
      req_ch.speed_scale <= sc;
      req_ch.hold <= hold;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      motion_sb.note_item(k, tgt, sc, hold);
      sent++;
      @(negedge clock);
   endtask

   task automatic go_idle();
      req_ch.valid <= 0;
      while (motion_sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);   // extra idle margin after the last result
   endtask

   task automatic set_reg(srpg_pkg::csr_type idx, logic [15:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      motion_sb.write_reg(idx, val);
   endtask

   // A short move: start then ticks until done or max_ticks is reached, with random holds.
   task automatic run_move(logic signed [31:0] tgt, logic [15:0] sc, int max_ticks, bit gaps);
      int n;
      send_item(srpg_pkg::KIND_START, tgt, sc, 0, gaps);
      n = 0;
      while (motion_sb.phase != srpg_pkg::PH_IDLE && n < max_ticks) begin
         send_item(srpg_pkg::KIND_TICK, $urandom, 16'($urandom),
                   ($urandom_range(0, 9) == 0), gaps);
         n++;
      end
   endtask

   // Receiver: waits a drawn number of cycles per item, samples at the rising edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (rx_wait > 0) begin
            rsp_ch.ready <= 1'b0;
            rx_wait--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         motion_sb.check_result({rsp_ch.step_pulse, rsp_ch.direction, rsp_ch.position,
                                 rsp_ch.busy_res, rsp_ch.done_res});
         rx_wait = stalls_on ? int'($urandom_range(0, 19)) : 0;
      end
   end

   initial begin
      int r;
      logic signed [31:0] tgt;
      motion_sb.clear_state();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: fast ramp so moves finish in few ticks.
      set_reg(srpg_pkg::CSR_FIRST, 16'd6);
      set_reg(srpg_pkg::CSR_MIN, 16'd2);
      run_move(32'sd5, 16'd256, 200, 0);           // positive move, full ramp profile
      run_move(-32'sd3, 16'd300, 200, 0);          // negative direction
      // target equals position: stays idle
      send_item(srpg_pkg::KIND_START, -32'sd3, 16'd256, 0, 0);
      send_item(srpg_pkg::KIND_TICK, 0, 0, 0, 0);  // tick while idle
      send_item(srpg_pkg::KIND_NOP, 32'sh7FFF_FFFF, 16'hFFFF, 1, 0);
      // zero scale: wait saturates low
      send_item(srpg_pkg::KIND_START, 32'sd4, 16'd0, 0, 0);
      send_item(srpg_pkg::KIND_TICK, 0, 0, 1, 0);  // held tick
      send_item(srpg_pkg::KIND_TICK, 0, 0, 0, 0);
      send_item(srpg_pkg::KIND_CLEAR, 0, 0, 0, 0); // clear while busy
      send_item(srpg_pkg::KIND_START, 32'sd2, 16'd256, 0, 0);  // restart while busy
      send_item(srpg_pkg::KIND_TICK, 0, 0, 0, 0);
      // most negative target
      send_item(srpg_pkg::KIND_START, 32'sh8000_0000, 16'hFFFF, 0, 0);
      send_item(srpg_pkg::KIND_TICK, 0, 0, 0, 0);
      // most positive target
      send_item(srpg_pkg::KIND_START, 32'sh7FFF_FFFF, 16'hFFFF, 0, 0);
      send_item(srpg_pkg::KIND_TICK, 0, 0, 0, 0);
      send_item(srpg_pkg::KIND_CLEAR, 0, 0, 0, 0);
      go_idle();

      // Random phases over several register settings, extremes included.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               set_reg(srpg_pkg::CSR_FIRST, 16'hFFFF);
               set_reg(srpg_pkg::CSR_MIN, 16'hFFFF);
            end
            1: begin
               set_reg(srpg_pkg::CSR_FIRST, 16'd1);
               set_reg(srpg_pkg::CSR_MIN, 16'd1);
            end
            2: begin
               set_reg(srpg_pkg::CSR_FIRST, 16'd2000);
               set_reg(srpg_pkg::CSR_MIN, 16'd100);
            end
            default: begin
               set_reg(srpg_pkg::CSR_FIRST, 16'($urandom_range(1, 12)));
               set_reg(srpg_pkg::CSR_MIN, 16'($urandom_range(1, 4)));
            end
         endcase
         stalls_on = (ph != 3);
         for (int m = 0; m < 6; m++) begin
            r = int'($urandom_range(0, 9));
            tgt = motion_sb.pos + 32'($urandom_range(0, 12)) - 32'd6;
            if (r == 0)
               send_item(srpg_pkg::KIND_CLEAR, $urandom, 16'($urandom), 1'($urandom), 1);
            else if (r == 1)
               send_item(srpg_pkg::KIND_NOP, $urandom, 16'($urandom), 1'($urandom), 1);
            else if (r == 2)
               send_item(srpg_pkg::KIND_START, $urandom, 16'($urandom), 0, 1);
            // Large scales and slow registers make waits long; keep those short.
            run_move(tgt, (r == 3) ? 16'($urandom) : 16'($urandom_range(0, 400)),
                     (ph < 3) ? 6 : 24, 1);
         end
         go_idle();
      end
      $display("covered %0d items: %0d steps, %0d completed moves, six register settings",
               sent, motion_sb.steps_seen, motion_sb.moves_done);
      if (motion_sb.errors == 0 && motion_sb.pending.size() == 0)
         $display("stepper_ramp_pulse_generator: match");
      else
         $display("stepper_ramp_pulse_generator: mismatch");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("stepper_ramp_pulse_generator: mismatch");
      $finish;
   end

endmodule
